/* rtl/crcfr_pkg.sv */
// Shared types, codes and the CRC-16-CCITT byte update for the frame receiver.
package crcfr_pkg;

  localparam logic [7:0]  PREAMBLE_BYTE = 8'h55;
  localparam logic [15:0] CRC_POLY      = 16'h1021;
  localparam logic [15:0] LOW_MASK      = 16'h00ff;
  localparam logic [15:0] HIGH_MASK     = 16'hff00;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_PAYLOAD = 2'd0;
  localparam kind_t KIND_GOOD    = 2'd1;
  localparam kind_t KIND_CRC_ERR = 2'd2;

  typedef struct packed {
    kind_t       result_kind;
    logic        frame_end;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [15:0] message_type;
    logic [15:0] source_id;
    logic [7:0]  payload_length;
    logic [15:0] received_crc;
    logic [15:0] computed_crc;
  } result_t;

  // MSB-first CRC-16-CCITT update over one byte, no reflection.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* rtl/crc16_frame_receiver.sv */
// Top level of the preamble / length / CRC-16-CCITT frame receiver.
//
// in_*  : one received byte per request (in_tdata). Bytes are parsed as
//         preamble 0x55, type (LE16), sender (LE16), length, payload, CRC (LE16).
// out_* : one result per payload byte and one per frame end. out_tuser is the
//         result kind (payload / good / CRC error), out_tlast marks frame end,
//         out_tdata carries the byte, its index, the header fields and CRCs.
// cfg_* : cfg_wr_en writes cfg_wr_data into the CRC check enable (reset 1);
//         write only while idle.
// Output: each result is registered into the result register, or the skid entry under stall.
// Throughput: one byte per cycle while in_tready is high; the per-byte CRC update is combinational.
// Stall: a result register plus a skid entry hold results; in_tready drops only
//         once both are full, and rises again when out_tready takes one.
// Reset: the parser returns to the preamble hunt, header and CRC state clear,
//         the output side empties.
module crc16_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // payload_byte, payload_index, message_type,
                                  // source_id, payload_length, received_crc,
                                  // computed_crc (lowest bit up)
  output logic [1:0]  out_tuser,  // [1:0] result_kind
  output logic        out_tlast   // frame_end
);

  logic               in_accept;
  logic               res_valid;
  crcfr_pkg::result_t res;
  crcfr_pkg::result_t out_res;

  assign in_accept = in_tvalid && in_tready;

  crcfr_deframer u_deframer (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .byte_valid  (in_accept),
    .rx_byte     (in_tdata),
    .res_valid   (res_valid),
    .res         (res)
  );

  crcfr_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .push_ready (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_res)
  );

  assign out_tdata = {out_res.computed_crc, out_res.received_crc, out_res.payload_length,
                      out_res.source_id, out_res.message_type, out_res.payload_index,
                      out_res.payload_byte};
  assign out_tuser = out_res.result_kind;
  assign out_tlast = out_res.frame_end;

endmodule

/* rtl/crcfr_deframer.sv */
// Frame parser: preamble hunt, header capture, running CRC and result build.
module crcfr_deframer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  logic                 byte_valid,
  input  logic [7:0]           rx_byte,
  output logic                 res_valid,
  output crcfr_pkg::result_t   res
);

  typedef enum logic [2:0] {
    PH_WAIT    = 3'd0,
    PH_TYPE    = 3'd1,
    PH_SENDER  = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CRC     = 3'd5
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [15:0] type_r, type_nxt;
  logic [15:0] sender_r, sender_nxt;
  logic [7:0]  length_r, length_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic        chk_en_r;

  logic [15:0] crc_upd;
  logic [15:0] rx_crc;
  logic [8:0]  idx_inc;

  assign crc_upd = crcfr_pkg::crc16_byte(crc_r, rx_byte);
  assign rx_crc  = {rx_byte, crc_lo_r};
  assign idx_inc = {1'b0, count_r} + 9'd1;

  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    type_nxt   = type_r;
    sender_nxt = sender_r;
    length_nxt = length_r;
    crc_nxt    = crc_r;
    crc_lo_nxt = crc_lo_r;
    res_valid  = 1'b0;
    res        = '0;
    res.message_type   = type_r;
    res.source_id      = sender_r;
    res.payload_length = length_r;
    if (byte_valid) begin
      unique case (phase_r)
        PH_WAIT: begin
          if (rx_byte == crcfr_pkg::PREAMBLE_BYTE) begin
            count_nxt  = '0;
            type_nxt   = '0;
            sender_nxt = '0;
            length_nxt = '0;
            crc_nxt    = '0;
            crc_lo_nxt = '0;
            phase_nxt  = PH_TYPE;
          end
        end
        PH_TYPE: begin
          crc_nxt = crc_upd;
          if (count_r == 8'd0) begin
            type_nxt  = (type_r & crcfr_pkg::HIGH_MASK) | {8'h00, rx_byte};
            count_nxt = 8'd1;
          end else begin
            type_nxt  = (type_r & crcfr_pkg::LOW_MASK) | {rx_byte, 8'h00};
            count_nxt = '0;
            phase_nxt = PH_SENDER;
          end
        end
        PH_SENDER: begin
          crc_nxt = crc_upd;
          if (count_r == 8'd0) begin
            sender_nxt = (sender_r & crcfr_pkg::HIGH_MASK) | {8'h00, rx_byte};
            count_nxt  = 8'd1;
          end else begin
            sender_nxt = (sender_r & crcfr_pkg::LOW_MASK) | {rx_byte, 8'h00};
            count_nxt  = '0;
            phase_nxt  = PH_LEN;
          end
        end
        PH_LEN: begin
          crc_nxt    = crc_upd;
          length_nxt = rx_byte;
          count_nxt  = '0;
          phase_nxt  = (rx_byte == 8'd0) ? PH_CRC : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          crc_nxt           = crc_upd;
          res_valid         = 1'b1;
          res.result_kind   = crcfr_pkg::KIND_PAYLOAD;
          res.payload_byte  = rx_byte;
          res.payload_index = count_r;
          if (idx_inc >= {1'b0, length_r}) begin
            count_nxt = '0;
            phase_nxt = PH_CRC;
          end else begin
            count_nxt = idx_inc[7:0];
          end
        end
        PH_CRC: begin
          if (count_r == 8'd0) begin
            crc_lo_nxt = rx_byte;
            count_nxt  = 8'd1;
          end else begin
            res_valid        = 1'b1;
            res.frame_end    = 1'b1;
            res.received_crc = rx_crc;
            res.computed_crc = crc_r;
            res.result_kind  = (!chk_en_r || rx_crc == crc_r) ?
                               crcfr_pkg::KIND_GOOD : crcfr_pkg::KIND_CRC_ERR;
            count_nxt        = '0;
            phase_nxt        = PH_WAIT;
          end
        end
        default: begin
          // unused phase code: drop the byte and resync
          phase_nxt = PH_WAIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_WAIT;
      count_r  <= '0;
      type_r   <= '0;
      sender_r <= '0;
      length_r <= '0;
      crc_r    <= '0;
      crc_lo_r <= '0;
      chk_en_r <= 1'b1;
    end else begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      type_r   <= type_nxt;
      sender_r <= sender_nxt;
      length_r <= length_nxt;
      crc_r    <= crc_nxt;
      crc_lo_r <= crc_lo_nxt;
      if (cfg_wr_en) begin
        chk_en_r <= cfg_wr_data;
      end
    end
  end

endmodule

/* rtl/crcfr_out_buf.sv */
// Result register with a skid stage that holds one more result while the output stalls.
module crcfr_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  crcfr_pkg::result_t   push_data,
  output logic                 push_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output crcfr_pkg::result_t   out_data
);

  logic               out_valid_r;
  logic               skid_valid_r;
  crcfr_pkg::result_t out_data_r;
  crcfr_pkg::result_t skid_data_r;

  assign push_ready = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_ready) begin
        // output slot frees up: refill from skid first, else from the new request
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= push;
        end
      end else if (push) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_data_r <= skid_valid_r ? skid_data_r : push_data;
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

endmodule

/* sim/crc16_frame_receiver_tb.sv */
// Self-checking bench for the frame receiver: random and directed byte streams.
module crc16_frame_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Parser copy: follows the byte stream and queues the results it should produce.
  class frame_tracker;
    typedef enum logic [2:0] {
      ST_HUNT, ST_TYPE, ST_SENDER, ST_LEN, ST_PAYLOAD, ST_CRC
    } parse_state_t;

    logic                 crc_check = 1'b1;
    parse_state_t         state = ST_HUNT;
    logic [7:0]           byte_cnt = '0;
    logic [15:0]          hdr_type = '0;
    logic [15:0]          sender = '0;
    logic [7:0]           length = '0;
    logic [15:0]          crc_acc = '0;
    logic [7:0]           crc_lo = '0;
    crcfr_pkg::result_t   pending[$];
    int                   fault_count = 0;

    static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ b[i];
        c = {c[14:0], 1'b0};
        if (fb) c = c ^ crcfr_pkg::CRC_POLY;
      end
      return c;
    endfunction

    function void take_byte(logic [7:0] b);
      crcfr_pkg::result_t r;
      r = '0;
      case (state)
        ST_HUNT: begin
          if (b == crcfr_pkg::PREAMBLE_BYTE) begin
            byte_cnt = '0;
            hdr_type = '0;
            sender = '0;
            length = '0;
            crc_acc = '0;
            crc_lo = '0;
            state = ST_TYPE;
          end
        end
        ST_TYPE: begin
          crc_acc = crc_step(crc_acc, b);
          if (byte_cnt == 0) begin
            hdr_type[7:0] = b;
            byte_cnt = 8'd1;
          end else begin
            hdr_type[15:8] = b;
            byte_cnt = '0;
            state = ST_SENDER;
          end
        end
        ST_SENDER: begin
          crc_acc = crc_step(crc_acc, b);
          if (byte_cnt == 0) begin
            sender[7:0] = b;
            byte_cnt = 8'd1;
          end else begin
            sender[15:8] = b;
            byte_cnt = '0;
            state = ST_LEN;
          end
        end
        ST_LEN: begin
          crc_acc = crc_step(crc_acc, b);
          length = b;
          byte_cnt = '0;
          state = (b == 0) ? ST_CRC : ST_PAYLOAD;
        end
        ST_PAYLOAD: begin
          crc_acc = crc_step(crc_acc, b);
          r.result_kind = crcfr_pkg::KIND_PAYLOAD;
          r.payload_byte = b;
          r.payload_index = byte_cnt;
          r.message_type = hdr_type;
          r.source_id = sender;
          r.payload_length = length;
          pending.push_back(r);
          if (int'(byte_cnt) + 1 >= int'(length)) begin
            byte_cnt = '0;
            state = ST_CRC;
          end else begin
            byte_cnt = byte_cnt + 8'd1;
          end
        end
        ST_CRC: begin
          if (byte_cnt == 0) begin
            crc_lo = b;
            byte_cnt = 8'd1;
          end else begin
            r.received_crc = {b, crc_lo};
            r.computed_crc = crc_acc;
            r.result_kind = (!crc_check || r.received_crc == crc_acc) ?
                            crcfr_pkg::KIND_GOOD : crcfr_pkg::KIND_CRC_ERR;
            r.message_type = hdr_type;
            r.source_id = sender;
            r.payload_length = length;
            r.frame_end = 1'b1;
            pending.push_back(r);
            byte_cnt = '0;
            state = ST_HUNT;
          end
        end
        default: state = ST_HUNT;
      endcase
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        fault_count++;
      end
    endfunction

    function void match_result(logic [87:0] tdata, logic [1:0] tuser, logic tlast);
      crcfr_pkg::result_t want;
      if (pending.size() == 0) begin
        $error("result_kind: expected none, got 0x%0h", tuser);
        fault_count++;
        return;
      end
      want = pending.pop_front();
      compare("result_kind", 16'(want.result_kind), 16'(tuser));
      compare("payload_byte", 16'(want.payload_byte), 16'(tdata[7:0]));
      compare("payload_index", 16'(want.payload_index), 16'(tdata[15:8]));
      compare("message_type", want.message_type, tdata[31:16]);
      compare("source_id", want.source_id, tdata[47:32]);
      compare("payload_length", 16'(want.payload_length), 16'(tdata[55:48]));
      compare("received_crc", want.received_crc, tdata[71:56]);
      compare("computed_crc", want.computed_crc, tdata[87:72]);
      compare("frame_end", 16'(want.frame_end), 16'(tlast));
    endfunction
  endclass

  localparam int DRAIN_LIMIT = 50000;
  localparam int PHASE_BYTES = 530;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  frame_tracker tracker = new();
  int           send_gap_pct = 0;
  int           recv_stall_pct = 0;
  int           bytes_sent = 0;
  logic [7:0]   payload_bytes[$];

  crc16_frame_receiver dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tracker.match_result(out_tdata, out_tuser, out_tlast);
    end
  end

  // Call at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    tracker.take_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Send a complete frame carrying payload_bytes; optionally corrupt the CRC.
  task automatic send_frame(input logic [15:0] mtype, input logic [15:0] sid, input bit bad_crc);
    logic [15:0] crc;
    logic [7:0]  hdr[5];
    crc = '0;
    hdr[0] = mtype[7:0];
    hdr[1] = mtype[15:8];
    hdr[2] = sid[7:0];
    hdr[3] = sid[15:8];
    hdr[4] = 8'(payload_bytes.size());
    send_byte(crcfr_pkg::PREAMBLE_BYTE);
    foreach (hdr[i]) begin
      crc = frame_tracker::crc_step(crc, hdr[i]);
      send_byte(hdr[i]);
    end
    foreach (payload_bytes[i]) begin
      crc = frame_tracker::crc_step(crc, payload_bytes[i]);
      send_byte(payload_bytes[i]);
    end
    if (bad_crc) crc = crc ^ 16'($urandom_range(65535, 1));
    send_byte(crc[7:0]);
    send_byte(crc[15:8]);
  endtask

  task automatic drain(input int extra);
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (tracker.pending.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_check_enable(input logic en);
    drain(4);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= en;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    tracker.crc_check = en;
  endtask

  task automatic random_traffic(input int min_bytes);
    int start;
    int pick;
    int len;
    start = bytes_sent;
    while (bytes_sent - start < min_bytes) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        len = $urandom_range(99);
        if (len < 3) len = 255;
        else if (len < 6) len = $urandom_range(254, 100);
        else if (len < 18) len = $urandom_range(40, 9);
        else len = $urandom_range(8, 0);
        payload_bytes.delete();
        repeat (len) payload_bytes.push_back(8'($urandom));
        send_frame(16'($urandom), 16'($urandom), $urandom_range(3) == 0);
      end else if (pick < 85) begin
        // line noise between frames
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
      end else begin
        // frame cut short: the following bytes get folded into it
        send_byte(crcfr_pkg::PREAMBLE_BYTE);
        repeat ($urandom_range(6, 1)) send_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_gap_pct = 22;
    recv_stall_pct = 75;
    // dropped while hunting
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hAA);
    // empty payload goes straight to the CRC
    payload_bytes.delete();
    send_frame(16'h0000, 16'hFFFF, 1'b0);
    // preamble value inside the header and payload, bad CRC
    payload_bytes.delete();
    payload_bytes.push_back(crcfr_pkg::PREAMBLE_BYTE);
    payload_bytes.push_back(8'hFF);
    send_frame(16'h5555, 16'h00FF, 1'b1);

    write_check_enable(1'b0);
    random_traffic(PHASE_BYTES);

    send_gap_pct = 75;
    recv_stall_pct = 22;
    write_check_enable(1'b1);
    random_traffic(PHASE_BYTES);

    send_gap_pct = 0;
    recv_stall_pct = 0;
    write_check_enable(1'b0);
    random_traffic(PHASE_BYTES / 2);
    write_check_enable(1'b1);
    random_traffic(PHASE_BYTES / 2);

    drain(10);
    if (tracker.pending.size() != 0) begin
      $error("results missing: %0d still outstanding", tracker.pending.size());
      tracker.fault_count++;
    end
    if (tracker.fault_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
